// ===== hdl/pcat_pkg.sv =====
// ----------------------------------------------------------------------------
// pcat_pkg
// Types and constants shared by the path command affine transform block.
// ----------------------------------------------------------------------------
package pcat_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int FUNC_W        = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int PROD_W        = 2 * COORD_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_MOVE  = 3'd0,
    FN_LINE  = 3'd1,
    FN_QUAD  = 3'd2,
    FN_CUBIC = 3'd3,
    FN_CLOSE = 3'd4
  } pcat_func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_M_XX = 3'd0,
    CFG_M_XY = 3'd1,
    CFG_M_XT = 3'd2,
    CFG_M_YX = 3'd3,
    CFG_M_YY = 3'd4,
    CFG_M_YT = 3'd5
  } pcat_cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] xx;
    logic signed [COORD_W-1:0] xy;
    logic signed [COORD_W-1:0] xt;
    logic signed [COORD_W-1:0] yx;
    logic signed [COORD_W-1:0] yy;
    logic signed [COORD_W-1:0] yt;
  } pcat_coef_t;

  typedef struct packed {
    logic ld0;
    logic ld1;
    logic ld2;
    logic ld3;
  } pcat_adv_t;

endpackage

// ===== hdl/pcat_ifs.sv =====
// ----------------------------------------------------------------------------
// pcat channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface pcat_in_if;
  logic                               valid;
  logic                               ready;
  logic [pcat_pkg::FUNC_W-1:0]        func;
  logic signed [pcat_pkg::COORD_W-1:0] pt0_x;
  logic signed [pcat_pkg::COORD_W-1:0] pt0_y;
  logic signed [pcat_pkg::COORD_W-1:0] pt1_x;
  logic signed [pcat_pkg::COORD_W-1:0] pt1_y;
  logic signed [pcat_pkg::COORD_W-1:0] pt2_x;
  logic signed [pcat_pkg::COORD_W-1:0] pt2_y;

  modport source (output valid, func, pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y,
                  input ready);
  modport sink (input valid, func, pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y,
                output ready);
endinterface

interface pcat_out_if;
  logic                               valid;
  logic                               ready;
  logic [pcat_pkg::FUNC_W-1:0]        out_func;
  logic signed [pcat_pkg::COORD_W-1:0] out0_x;
  logic signed [pcat_pkg::COORD_W-1:0] out0_y;
  logic signed [pcat_pkg::COORD_W-1:0] out1_x;
  logic signed [pcat_pkg::COORD_W-1:0] out1_y;
  logic signed [pcat_pkg::COORD_W-1:0] out2_x;
  logic signed [pcat_pkg::COORD_W-1:0] out2_y;
  logic                               saturated;

  modport source (output valid, out_func, out0_x, out0_y, out1_x, out1_y, out2_x,
                  out2_y, saturated, input ready);
  modport sink (input valid, out_func, out0_x, out0_y, out1_x, out1_y, out2_x,
                out2_y, saturated, output ready);
endinterface

interface pcat_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pcat_pkg::CFG_IDX_W-1:0]    index;
  logic [pcat_pkg::COORD_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/path_command_affine_transform.sv =====
// ----------------------------------------------------------------------------
// path_command_affine_transform
// Maps the points of vector path commands through a 2D affine transform.
// ----------------------------------------------------------------------------
// The block accepts one command item per clock while in_ch.ready is high and
// passes it through four registered stages to out_ch: an input register, a
// stage of 32x32 multipliers, a stage that rounds the products and adds the
// translation, and a saturating output register. Every stage holds its item
// while the output is stalled, so in_ch.ready falls only when all four stages
// are full and out_ch.ready is low. The coefficients are live, so they should
// be written only while no item is in flight.
module path_command_affine_transform #(
  parameter int FRAC_BITS = pcat_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pcat_in_if.sink     in_ch,
  pcat_out_if.source  out_ch,
  pcat_cfg_if.sink    cfg_ch
);
  import pcat_pkg::*;

  logic                v0_r, v1_r, v2_r, v3_r;
  logic [FUNC_W-1:0]   func0_r, func1_r, func2_r, func3_r;
  logic                take0, take1, take2, take3;
  logic [2:0]          used_s2;
  pcat_adv_t           adv;
  pcat_coef_t          coef;
  logic [2:0]          sat_pt;

  assign take3 = !v3_r || out_ch.ready;
  assign take2 = !v2_r || take3;
  assign take1 = !v1_r || take2;
  assign take0 = !v0_r || take1;

  assign adv.ld0 = in_ch.valid && take0;
  assign adv.ld1 = v0_r && take1;
  assign adv.ld2 = v1_r && take2;
  assign adv.ld3 = v2_r && take3;

  always_comb begin
    case (func2_r) inside
      FN_MOVE, FN_LINE: used_s2 = 3'b001;
      FN_QUAD:          used_s2 = 3'b011;
      FN_CUBIC:         used_s2 = 3'b111;
      default:          used_s2 = 3'b000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (take0) v0_r <= in_ch.valid;
      if (take1) v1_r <= v0_r;
      if (take2) v2_r <= v1_r;
      if (take3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.ld0) func0_r <= in_ch.func;
    if (adv.ld1) func1_r <= func0_r;
    if (adv.ld2) func2_r <= func1_r;
    if (adv.ld3) func3_r <= func2_r;
  end

  pcat_cfg_regs #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .coef     (coef)
  );

  assign cfg_ch.ready = 1'b1;

  pcat_point_unit #(.FRAC_BITS(FRAC_BITS)) u_pt0 (
    .clk     (clk),
    .adv     (adv),
    .coef    (coef),
    .x_in    (in_ch.pt0_x),
    .y_in    (in_ch.pt0_y),
    .used_s2 (used_s2[0]),
    .x_out   (out_ch.out0_x),
    .y_out   (out_ch.out0_y),
    .sat_out (sat_pt[0])
  );

  pcat_point_unit #(.FRAC_BITS(FRAC_BITS)) u_pt1 (
    .clk     (clk),
    .adv     (adv),
    .coef    (coef),
    .x_in    (in_ch.pt1_x),
    .y_in    (in_ch.pt1_y),
    .used_s2 (used_s2[1]),
    .x_out   (out_ch.out1_x),
    .y_out   (out_ch.out1_y),
    .sat_out (sat_pt[1])
  );

  pcat_point_unit #(.FRAC_BITS(FRAC_BITS)) u_pt2 (
    .clk     (clk),
    .adv     (adv),
    .coef    (coef),
    .x_in    (in_ch.pt2_x),
    .y_in    (in_ch.pt2_y),
    .used_s2 (used_s2[2]),
    .x_out   (out_ch.out2_x),
    .y_out   (out_ch.out2_y),
    .sat_out (sat_pt[2])
  );

  assign in_ch.ready      = take0;
  assign out_ch.valid     = v3_r;
  assign out_ch.out_func  = func3_r;
  assign out_ch.saturated = |sat_pt;

endmodule

// ===== hdl/pcat_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pcat_cfg_regs
// Holds the six transform coefficients and decodes register writes.
// ----------------------------------------------------------------------------
module pcat_cfg_regs #(
  parameter int FRAC_BITS = pcat_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [pcat_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [pcat_pkg::COORD_W-1:0]   wr_data,
  output pcat_pkg::pcat_coef_t           coef
);
  import pcat_pkg::*;

  localparam logic signed [COORD_W-1:0] ONE_Q = COORD_W'(1) << FRAC_BITS;

  pcat_coef_t coef_r;
  pcat_coef_t coef_nxt;

  always_comb begin
    coef_nxt = coef_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_M_XX: coef_nxt.xx = wr_data;
        CFG_M_XY: coef_nxt.xy = wr_data;
        CFG_M_XT: coef_nxt.xt = wr_data;
        CFG_M_YX: coef_nxt.yx = wr_data;
        CFG_M_YY: coef_nxt.yy = wr_data;
        CFG_M_YT: coef_nxt.yt = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.xx <= ONE_Q;
      coef_r.xy <= '0;
      coef_r.xt <= '0;
      coef_r.yx <= '0;
      coef_r.yy <= ONE_Q;
      coef_r.yt <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  assign coef = coef_r;

endmodule

// ===== hdl/pcat_point_unit.sv =====
// ----------------------------------------------------------------------------
// pcat_point_unit
// Four-stage datapath for one point: input register, products, rounded
// sums, and the saturating output register.
// ----------------------------------------------------------------------------
module pcat_point_unit #(
  parameter int FRAC_BITS = pcat_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  pcat_pkg::pcat_adv_t                 adv,
  input  pcat_pkg::pcat_coef_t                coef,
  input  logic signed [pcat_pkg::COORD_W-1:0] x_in,
  input  logic signed [pcat_pkg::COORD_W-1:0] y_in,
  input  logic                                used_s2,
  output logic signed [pcat_pkg::COORD_W-1:0] x_out,
  output logic signed [pcat_pkg::COORD_W-1:0] y_out,
  output logic                                sat_out
);
  import pcat_pkg::*;

  localparam int RND_W = PROD_W + 1;
  localparam int SUM_W = PROD_W + 2;
  localparam logic signed [RND_W-1:0] HALF =
    (RND_W'(1) << FRAC_BITS) >> 1;
  localparam logic signed [SUM_W-1:0] MAX_S = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] MIN_S = -MAX_S - SUM_W'(1);

  logic signed [COORD_W-1:0] x_r, y_r;
  logic signed [PROD_W-1:0]  p_xx_r, p_xy_r, p_yx_r, p_yy_r;
  logic signed [SUM_W-1:0]   sx_r, sy_r;
  logic signed [SUM_W-1:0]   sx_nxt, sy_nxt;
  logic signed [COORD_W-1:0] ox_r, oy_r, ox_nxt, oy_nxt;
  logic                      sat_r, sat_nxt;
  logic signed [RND_W-1:0]   r_xx, r_xy, r_yx, r_yy;

  always_comb begin
    r_xx = (RND_W'(p_xx_r) + HALF) >>> FRAC_BITS;
    r_xy = (RND_W'(p_xy_r) + HALF) >>> FRAC_BITS;
    r_yx = (RND_W'(p_yx_r) + HALF) >>> FRAC_BITS;
    r_yy = (RND_W'(p_yy_r) + HALF) >>> FRAC_BITS;
    sx_nxt = SUM_W'(r_xx) + SUM_W'(r_xy) + SUM_W'(coef.xt);
    sy_nxt = SUM_W'(r_yx) + SUM_W'(r_yy) + SUM_W'(coef.yt);
  end

  always_comb begin
    ox_nxt  = '0;
    oy_nxt  = '0;
    sat_nxt = 1'b0;
    if (used_s2) begin
      if (sx_r > MAX_S) begin
        ox_nxt  = MAX_S[COORD_W-1:0];
        sat_nxt = 1'b1;
      end else if (sx_r < MIN_S) begin
        ox_nxt  = MIN_S[COORD_W-1:0];
        sat_nxt = 1'b1;
      end else begin
        ox_nxt = sx_r[COORD_W-1:0];
      end
      if (sy_r > MAX_S) begin
        oy_nxt  = MAX_S[COORD_W-1:0];
        sat_nxt = 1'b1;
      end else if (sy_r < MIN_S) begin
        oy_nxt  = MIN_S[COORD_W-1:0];
        sat_nxt = 1'b1;
      end else begin
        oy_nxt = sy_r[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.ld0) begin
      x_r <= x_in;
      y_r <= y_in;
    end
    if (adv.ld1) begin
      p_xx_r <= coef.xx * x_r;
      p_xy_r <= coef.xy * y_r;
      p_yx_r <= coef.yx * x_r;
      p_yy_r <= coef.yy * y_r;
    end
    if (adv.ld2) begin
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
    end
    if (adv.ld3) begin
      ox_r  <= ox_nxt;
      oy_r  <= oy_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign x_out   = ox_r;
  assign y_out   = oy_r;
  assign sat_out = sat_r;

endmodule

// ===== hdl/pcat_checker.sv =====
// ----------------------------------------------------------------------------
// pcat_checker
// Port-level checks for the path command affine transform block.
// ----------------------------------------------------------------------------
module pcat_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [pcat_pkg::FUNC_W-1:0]         out_func,
  input logic signed [pcat_pkg::COORD_W-1:0] out0_x,
  input logic signed [pcat_pkg::COORD_W-1:0] out0_y,
  input logic signed [pcat_pkg::COORD_W-1:0] out1_x,
  input logic signed [pcat_pkg::COORD_W-1:0] out1_y,
  input logic signed [pcat_pkg::COORD_W-1:0] out2_x,
  input logic signed [pcat_pkg::COORD_W-1:0] out2_y,
  input logic                                saturated
);
  import pcat_pkg::*;

  localparam logic [COORD_W-1:0] SAT_HI = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] SAT_LO = {1'b1, {(COORD_W-1){1'b0}}};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_no_points: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_func != FN_MOVE && out_func != FN_LINE &&
    out_func != FN_QUAD && out_func != FN_CUBIC |->
    out0_x == '0 && out0_y == '0 && out1_x == '0 && out1_y == '0 &&
    out2_x == '0 && out2_y == '0 && !saturated)
    else $error("command without points carries point data");

  a_one_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_func == FN_MOVE || out_func == FN_LINE) |->
    out1_x == '0 && out1_y == '0 && out2_x == '0 && out2_y == '0)
    else $error("unused point fields are not zero");

  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |->
    out0_x == SAT_HI || out0_x == SAT_LO || out0_y == SAT_HI || out0_y == SAT_LO ||
    out1_x == SAT_HI || out1_x == SAT_LO || out1_y == SAT_HI || out1_y == SAT_LO ||
    out2_x == SAT_HI || out2_x == SAT_LO || out2_y == SAT_HI || out2_y == SAT_LO)
    else $error("saturation flag without a limit value");

endmodule

bind path_command_affine_transform pcat_checker u_pcat_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_func  (out_ch.out_func),
  .out0_x    (out_ch.out0_x),
  .out0_y    (out_ch.out0_y),
  .out1_x    (out_ch.out1_x),
  .out1_y    (out_ch.out1_y),
  .out2_x    (out_ch.out2_x),
  .out2_y    (out_ch.out2_y),
  .saturated (out_ch.saturated)
);
